// File: rtl/color_gradient_lookup_macros.svh
// assertion helpers shared by the gradient lookup files
`ifndef COLOR_GRADIENT_LOOKUP_MACROS_SVH
`define COLOR_GRADIENT_LOOKUP_MACROS_SVH

// same-cycle implication, checked on every rising edge out of reset
`define CGL_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define CGL_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/cgl_pkg.sv
package cgl_pkg;

	// table geometry
	localparam int MAX_POINTS = 16;
	localparam int IDX_W      = $clog2(MAX_POINTS);
	localparam int CNT_W      = $clog2(MAX_POINTS + 1);

	// position format, unsigned Q1.FRAC_BITS
	localparam int FRAC_BITS = 12;
	localparam int POS_W     = FRAC_BITS + 1;
	localparam logic [POS_W-1:0] POS_ONE = POS_W'(1) << FRAC_BITS;

	// blend fraction, Q.16
	localparam int F_BITS = 16;
	localparam int QUO_W  = POS_W + F_BITS;
	localparam int F_W    = QUO_W + 1;

	localparam int CH_W  = 8;
	localparam int COL_W = 4 * CH_W;

	// command codes
	localparam logic [1:0] CMD_CLEAR  = 2'd0;
	localparam logic [1:0] CMD_APPEND = 2'd1;
	localparam int         CMD_QUERY_BIT = 1;

	// status codes
	localparam logic [1:0] STAT_QUERY   = 2'd0;
	localparam logic [1:0] STAT_STORED  = 2'd1;
	localparam logic [1:0] STAT_DROPPED = 2'd2;
	localparam logic [1:0] STAT_CLEARED = 2'd3;

	// opaque black, alpha in the top byte
	localparam logic [COL_W-1:0] COL_EMPTY = {8'hff, 8'h00, 8'h00, 8'h00};

	// write request into the stop memory
	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] addr;
		logic [POS_W-1:0] pos;
		logic [COL_W-1:0] color;
	} stop_wr_t;

	// divider result
	typedef struct packed {
		logic             done;
		logic [QUO_W-1:0] quo;
		logic             rem_nz;
	} div_res_t;

	// clamp a position to 1.0
	function automatic logic [POS_W-1:0] pos_sat(input logic [POS_W-1:0] p);
		pos_sat = (p > POS_ONE) ? POS_ONE : p;
	endfunction

endpackage

// File: rtl/cgl_if.sv
// command word into the lookup
interface cgl_req_if;
	logic                       valid;
	logic                       ready;
	logic [1:0]                 command;
	logic [cgl_pkg::POS_W-1:0]  position;
	logic [cgl_pkg::CH_W-1:0]   red;
	logic [cgl_pkg::CH_W-1:0]   green;
	logic [cgl_pkg::CH_W-1:0]   blue;
	logic [cgl_pkg::CH_W-1:0]   alpha;

	modport source (output valid, command, position, red, green, blue, alpha, input ready);
	modport sink   (input valid, command, position, red, green, blue, alpha, output ready);
endinterface

// result word out of the lookup
interface cgl_rsp_if;
	logic                       valid;
	logic                       ready;
	logic [cgl_pkg::CH_W-1:0]   red_out;
	logic [cgl_pkg::CH_W-1:0]   green_out;
	logic [cgl_pkg::CH_W-1:0]   blue_out;
	logic [cgl_pkg::CH_W-1:0]   alpha_out;
	logic [1:0]                 status;
	logic [cgl_pkg::CNT_W-1:0]  stop_count;

	modport source (output valid, red_out, green_out, blue_out, alpha_out, status, stop_count,
		input ready);
	modport sink   (input valid, red_out, green_out, blue_out, alpha_out, status, stop_count,
		output ready);
endinterface

// File: rtl/cgl_stop_mem.sv
module cgl_stop_mem (
	input  logic                        clk,
	input  cgl_pkg::stop_wr_t           wr,
	input  logic [cgl_pkg::IDX_W-1:0]   rd_addr,
	output logic [cgl_pkg::POS_W-1:0]   rd_pos,
	output logic [cgl_pkg::COL_W-1:0]   rd_color
);

	logic [cgl_pkg::POS_W-1:0] pos_mem [cgl_pkg::MAX_POINTS];
	logic [cgl_pkg::COL_W-1:0] col_mem [cgl_pkg::MAX_POINTS];

	// single write port
	always_ff @(posedge clk) begin
		if (wr.en) begin
			pos_mem[wr.addr] <= wr.pos;
			col_mem[wr.addr] <= wr.color;
		end
	end

	// registered read
	always_ff @(posedge clk) begin
		rd_pos   <= pos_mem[rd_addr];
		rd_color <= col_mem[rd_addr];
	end

endmodule

// File: rtl/cgl_div.sv
`include "color_gradient_lookup_macros.svh"

module cgl_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [cgl_pkg::QUO_W-1:0]   dividend,
	input  logic [cgl_pkg::POS_W-1:0]   divisor,
	output cgl_pkg::div_res_t           res
);

	localparam int STEP_W = $clog2(cgl_pkg::QUO_W);

	logic [cgl_pkg::QUO_W-1:0] quo_q;
	logic [cgl_pkg::POS_W-1:0] rem_q;
	logic [cgl_pkg::POS_W-1:0] den_q;
	logic [STEP_W-1:0]         cnt_q;
	logic                      busy_q;
	logic                      done_q;
	logic [cgl_pkg::POS_W:0]   shifted;
	logic [cgl_pkg::POS_W+1:0] trial;

	// restoring step: shift one dividend bit in, try the subtract
	assign shifted = {rem_q, quo_q[cgl_pkg::QUO_W-1]};
	assign trial   = {1'b0, shifted} - {2'b00, den_q};

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !start && busy_q && (cnt_q == '0);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= STEP_W'(cgl_pkg::QUO_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - STEP_W'(1);
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// datapath, one quotient bit a cycle
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			den_q <= divisor;
		end else if (busy_q) begin
			if (!trial[cgl_pkg::POS_W+1]) begin
				rem_q <= trial[cgl_pkg::POS_W-1:0];
				quo_q <= {quo_q[cgl_pkg::QUO_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[cgl_pkg::POS_W-1:0];
				quo_q <= {quo_q[cgl_pkg::QUO_W-2:0], 1'b0};
			end
		end
	end

	assign res.done   = done_q;
	assign res.quo    = quo_q;
	assign res.rem_nz = |rem_q;

	`CGL_ASSERT_NOW(a_start_idle, start, !busy_q, "divider restarted while busy")
	`CGL_ASSERT_NEXT(a_done_ends_busy, busy_q && cnt_q == '0, done_q && !busy_q, "divider stuck")

endmodule

// File: rtl/cgl_blend.sv
module cgl_blend (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic signed [cgl_pkg::F_W-1:0]    f,
	input  logic [cgl_pkg::COL_W-1:0]         lo_col,
	input  logic [cgl_pkg::COL_W-1:0]         hi_col,
	output logic                              done,
	output logic [cgl_pkg::COL_W-1:0]         color
);

	localparam int PROD_W = cgl_pkg::F_W + cgl_pkg::CH_W + 1;
	localparam int SUM_W  = PROD_W - cgl_pkg::F_BITS + 1;

	logic valid_s1;
	logic valid_s2;

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= start;
			valid_s2 <= valid_s1;
		end
	end

	// one lane per channel: multiply, then floor shift, add and clamp
	for (genvar k = 0; k < 4; k++) begin : g_lane
		logic [cgl_pkg::CH_W-1:0]    cl;
		logic [cgl_pkg::CH_W-1:0]    ch;
		logic signed [cgl_pkg::CH_W:0] diff;
		logic signed [PROD_W-1:0]    prod_s1;
		logic [cgl_pkg::CH_W-1:0]    cl_s1;
		logic signed [SUM_W-1:0]     sum;
		logic [cgl_pkg::CH_W-1:0]    col_s2;

		assign cl   = lo_col[k*cgl_pkg::CH_W +: cgl_pkg::CH_W];
		assign ch   = hi_col[k*cgl_pkg::CH_W +: cgl_pkg::CH_W];
		assign diff = $signed({1'b0, ch}) - $signed({1'b0, cl});

		always_ff @(posedge clk) begin
			prod_s1 <= diff * f;
			cl_s1   <= cl;
		end

		// arithmetic shift right is the floor divide by 65536
		assign sum = $signed({{(SUM_W - cgl_pkg::CH_W){1'b0}}, cl_s1})
			+ $signed({prod_s1[PROD_W-1], prod_s1[PROD_W-1:cgl_pkg::F_BITS]});

		always_ff @(posedge clk) begin
			if (sum < 0) begin
				col_s2 <= '0;
			end else if (sum > $signed(SUM_W'(255))) begin
				col_s2 <= '1;
			end else begin
				col_s2 <= sum[cgl_pkg::CH_W-1:0];
			end
		end

		assign color[k*cgl_pkg::CH_W +: cgl_pkg::CH_W] = col_s2;
	end

	assign done = valid_s2;

endmodule

// File: rtl/color_gradient_lookup.sv
// channel | dir | handshake    | payload
// req     | in  | valid/ready  | command, position, red, green, blue, alpha
// rsp     | out | valid/ready  | red_out, green_out, blue_out, alpha_out, status, stop_count
//
// clear, append and an empty-table query go from accept straight to ST_DONE and the output register.
// a query with N stops reads the last stop, scans all N stops for the bracket, reads the two
// colors, runs the serial divider and then the fraction and channel multiplies, and hands over;
// an exact hit or equal bracket skips divider and multiplies.
// one command in flight; the handover stalls while the output register waits on rsp.ready.
// arst_n clears the stop count and all control state; the stop memory is not cleared.
`include "color_gradient_lookup_macros.svh"

module color_gradient_lookup (
	input  logic       clk,
	input  logic       arst_n,
	cgl_req_if.sink    req,
	cgl_rsp_if.source  rsp
);

	typedef enum logic [7:0] {
		ST_IDLE  = 8'b0000_0001,
		ST_PREP  = 8'b0000_0010,
		ST_SCAN  = 8'b0000_0100,
		ST_COLLO = 8'b0000_1000,
		ST_COLHI = 8'b0001_0000,
		ST_DIV   = 8'b0010_0000,
		ST_BLEND = 8'b0100_0000,
		ST_DONE  = 8'b1000_0000
	} state_t;

	state_t state_q;

	logic [cgl_pkg::CNT_W-1:0] count_q;
	logic [cgl_pkg::IDX_W-1:0] last_idx;
	logic [cgl_pkg::IDX_W-1:0] scan_idx_q;
	logic [cgl_pkg::IDX_W-1:0] lo_idx_q;
	logic [cgl_pkg::IDX_W-1:0] up_idx_q;
	logic [cgl_pkg::POS_W-1:0] t_q;
	logic [cgl_pkg::POS_W-1:0] lo_pos_q;
	logic [cgl_pkg::POS_W-1:0] up_pos_q;
	logic [cgl_pkg::COL_W-1:0] lo_col_q;
	logic [cgl_pkg::COL_W-1:0] hi_col_q;
	logic                      neg_q;
	logic signed [cgl_pkg::F_W-1:0] f_q;
	logic                      blend_go_q;

	logic [cgl_pkg::COL_W-1:0] res_col_q;
	logic [1:0]                res_stat_q;

	logic                      out_valid_q;
	logic [cgl_pkg::COL_W-1:0] out_col_q;
	logic [1:0]                out_stat_q;
	logic [cgl_pkg::CNT_W-1:0] out_cnt_q;

	cgl_pkg::stop_wr_t         wr;
	logic [cgl_pkg::IDX_W-1:0] rd_addr;
	logic [cgl_pkg::POS_W-1:0] rd_pos;
	logic [cgl_pkg::COL_W-1:0] rd_color;

	logic                      accept;
	logic                      is_query;
	logic                      full;
	logic                      load_out;
	logic                      scan_last;
	logic                      take_lo;
	logic                      take_up;
	logic [cgl_pkg::IDX_W-1:0] lo_idx_next;

	logic signed [cgl_pkg::POS_W:0] num_diff;
	logic signed [cgl_pkg::POS_W:0] den_diff;
	logic [cgl_pkg::POS_W:0]        num_abs;
	logic [cgl_pkg::POS_W:0]        den_abs;
	logic                      hit_lo;
	logic                      hit_hi;
	logic                      pick_lo;
	logic                      div_start;
	cgl_pkg::div_res_t         div_res;
	logic [cgl_pkg::F_W-1:0]   f_mag;
	logic                      blend_done;
	logic [cgl_pkg::COL_W-1:0] blend_col;

	// input side
	assign req.ready = (state_q == ST_IDLE);
	assign accept    = req.valid && req.ready;
	assign is_query  = req.command[cgl_pkg::CMD_QUERY_BIT];
	assign full      = (count_q == cgl_pkg::CNT_W'(cgl_pkg::MAX_POINTS));
	assign last_idx  = cgl_pkg::IDX_W'(count_q - cgl_pkg::CNT_W'(1));
	assign load_out  = (state_q == ST_DONE) && (!out_valid_q || rsp.ready);

	// append writes straight into the stop memory at accept, unless the table is full
	assign wr.en    = accept && (req.command == cgl_pkg::CMD_APPEND) && !full;
	assign wr.addr  = count_q[cgl_pkg::IDX_W-1:0];
	assign wr.pos   = cgl_pkg::pos_sat(req.position);
	assign wr.color = {req.alpha, req.blue, req.green, req.red};

	// scan compare on the stop that just came out of memory
	assign scan_last   = (scan_idx_q == last_idx);
	assign take_lo     = (rd_pos <= t_q) || (scan_idx_q == '0);
	assign take_up     = (rd_pos >= t_q) && (rd_pos < up_pos_q);
	assign lo_idx_next = take_lo ? scan_idx_q : lo_idx_q;

	// read address: last stop first, then every stop in order, then both colors
	always_comb begin
		case (state_q)
			ST_IDLE:  rd_addr = last_idx;
			ST_PREP:  rd_addr = '0;
			ST_SCAN:  rd_addr = scan_last ? lo_idx_next : scan_idx_q + cgl_pkg::IDX_W'(1);
			ST_COLLO: rd_addr = up_idx_q;
			default:  rd_addr = '0;
		endcase
	end

	cgl_stop_mem u_mem (
		.clk      (clk),
		.wr       (wr),
		.rd_addr  (rd_addr),
		.rd_pos   (rd_pos),
		.rd_color (rd_color)
	);

	// bracket classification
	assign hit_lo   = (lo_pos_q == t_q);
	assign hit_hi   = (up_pos_q == t_q);
	assign pick_lo  = hit_lo || (!hit_hi && (up_pos_q == lo_pos_q));
	assign num_diff = $signed({1'b0, t_q}) - $signed({1'b0, lo_pos_q});
	assign den_diff = $signed({1'b0, up_pos_q}) - $signed({1'b0, lo_pos_q});
	assign num_abs  = num_diff[cgl_pkg::POS_W] ? -num_diff : num_diff;
	assign den_abs  = den_diff[cgl_pkg::POS_W] ? -den_diff : den_diff;
	assign div_start = (state_q == ST_COLHI) && !pick_lo && !hit_hi;

	cgl_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend ({num_abs[cgl_pkg::POS_W-1:0], {cgl_pkg::F_BITS{1'b0}}}),
		.divisor  (den_abs[cgl_pkg::POS_W-1:0]),
		.res      (div_res)
	);

	// floor rounding: a negative quotient with a remainder steps one further down
	assign f_mag = {1'b0, div_res.quo} + cgl_pkg::F_W'(neg_q && div_res.rem_nz);

	cgl_blend u_blend (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (blend_go_q),
		.f      (f_q),
		.lo_col (lo_col_q),
		.hi_col (hi_col_q),
		.done   (blend_done),
		.color  (blend_col)
	);

	// sequencer and stop count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			count_q    <= '0;
			blend_go_q <= 1'b0;
		end else begin
			blend_go_q <= (state_q == ST_DIV) && div_res.done;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (is_query) begin
							state_q <= (count_q == '0) ? ST_DONE : ST_PREP;
						end else begin
							state_q <= ST_DONE;
							if (req.command == cgl_pkg::CMD_CLEAR) begin
								count_q <= '0;
							end else if (!full) begin
								count_q <= count_q + cgl_pkg::CNT_W'(1);
							end
						end
					end
				end
				ST_PREP:  state_q <= ST_SCAN;
				ST_SCAN:  if (scan_last) state_q <= ST_COLLO;
				ST_COLLO: state_q <= ST_COLHI;
				ST_COLHI: state_q <= div_start ? ST_DIV : ST_DONE;
				ST_DIV:   if (div_res.done) state_q <= ST_BLEND;
				ST_BLEND: if (blend_done) state_q <= ST_DONE;
				ST_DONE:  if (load_out) state_q <= ST_IDLE;
				default:  state_q <= ST_IDLE;
			endcase
		end
	end

	// query datapath and pending result
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				t_q <= cgl_pkg::pos_sat(req.position);
				if (is_query) begin
					res_stat_q <= cgl_pkg::STAT_QUERY;
					res_col_q  <= cgl_pkg::COL_EMPTY;
				end else begin
					res_col_q <= '0;
					if (req.command == cgl_pkg::CMD_CLEAR) begin
						res_stat_q <= cgl_pkg::STAT_CLEARED;
					end else begin
						res_stat_q <= full ? cgl_pkg::STAT_DROPPED : cgl_pkg::STAT_STORED;
					end
				end
			end
			ST_PREP: begin
				up_pos_q   <= rd_pos;
				up_idx_q   <= last_idx;
				lo_idx_q   <= '0;
				scan_idx_q <= '0;
			end
			ST_SCAN: begin
				if (take_lo) begin
					lo_idx_q <= scan_idx_q;
					lo_pos_q <= rd_pos;
				end
				if (take_up) begin
					up_idx_q <= scan_idx_q;
					up_pos_q <= rd_pos;
				end
				scan_idx_q <= scan_idx_q + cgl_pkg::IDX_W'(1);
			end
			ST_COLLO: lo_col_q <= rd_color;
			ST_COLHI: begin
				hi_col_q <= rd_color;
				neg_q    <= num_diff[cgl_pkg::POS_W] ^ den_diff[cgl_pkg::POS_W];
				if (pick_lo) begin
					res_col_q <= lo_col_q;
				end else if (hit_hi) begin
					res_col_q <= rd_color;
				end
			end
			ST_DIV: f_q <= neg_q ? -$signed(f_mag) : $signed(f_mag);
			ST_BLEND: if (blend_done) res_col_q <= blend_col;
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_col_q  <= res_col_q;
			out_stat_q <= res_stat_q;
			out_cnt_q  <= count_q;
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.red_out    = out_col_q[0*cgl_pkg::CH_W +: cgl_pkg::CH_W];
	assign rsp.green_out  = out_col_q[1*cgl_pkg::CH_W +: cgl_pkg::CH_W];
	assign rsp.blue_out   = out_col_q[2*cgl_pkg::CH_W +: cgl_pkg::CH_W];
	assign rsp.alpha_out  = out_col_q[3*cgl_pkg::CH_W +: cgl_pkg::CH_W];
	assign rsp.status     = out_stat_q;
	assign rsp.stop_count = out_cnt_q;

	`CGL_ASSERT_NOW(a_count_max, 1'b1, count_q <= cgl_pkg::CNT_W'(cgl_pkg::MAX_POINTS), "count over max")
	`CGL_ASSERT_NOW(a_wr_room, wr.en, !full && state_q == ST_IDLE, "stop written into a full table")
	`CGL_ASSERT_NOW(a_div_state, div_res.done, state_q == ST_DIV, "divider done outside divide")
	`CGL_ASSERT_NEXT(a_load_out, load_out, out_valid_q && state_q == ST_IDLE, "result not loaded")

endmodule
